FILE: rtl/mvmp_pkg.sv
// ----------------------------------------------------------------------------
// mvmp_pkg: shared types and constants
// Field widths and the reduction step record for the vector-matrix product.
// ----------------------------------------------------------------------------
`default_nettype none
package mvmp_pkg;
  localparam int VAL_W   = 37;
  localparam int PROD_W  = 74;
  localparam int ACC_W   = 96;
  localparam int CNT_W   = 11;
  localparam int IDX_W   = 10;
  localparam int RED_CELLS = 24;   // cells in the reduction chain
  localparam int RED_BITS  = 4;    // accumulator bits consumed per cell
  localparam logic CFG_MODULUS      = 1'b0;
  localparam logic CFG_COLUMN_COUNT = 1'b1;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic              last_col;
    logic              zero_mod;
    val_t              p;
    val_t              r;
    acc_t              acc;
  } red_t;
endpackage
`default_nettype wire

FILE: rtl/mvmp_if.sv
// ----------------------------------------------------------------------------
// mvmp_in_if / mvmp_out_if: valid-ready channels
// Input and result channels of the vector-matrix product.
// ----------------------------------------------------------------------------
`default_nettype none
interface mvmp_in_if;
  logic                 valid;
  logic                 ready;
  logic [36:0]          coefficient;
  logic [36:0]          element;
  logic                 final_row;
  modport source (output valid, coefficient, element, final_row, input ready);
  modport sink   (input valid, coefficient, element, final_row, output ready);
endinterface

interface mvmp_out_if;
  logic                 valid;
  logic                 ready;
  logic [9:0]           column_index;
  logic [36:0]          reduced_sum;
  logic                 final_column;
  modport source (output valid, column_index, reduced_sum, final_column, input ready);
  modport sink   (input valid, column_index, reduced_sum, final_column, output ready);
endinterface
`default_nettype wire

FILE: rtl/mvmp_ram.sv
// ----------------------------------------------------------------------------
// mvmp_ram: generic simple dual-port RAM
// One write and one read address per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module mvmp_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/mvmp_red_cell.sv
// ----------------------------------------------------------------------------
// mvmp_red_cell: one cell of the reduction chain
// Folds RED_BITS accumulator bits into the running remainder, hands on.
// ----------------------------------------------------------------------------
`default_nettype none
module mvmp_red_cell (
  input  wire             clk,
  input  wire             rst_n,
  input  mvmp_pkg::red_t  din,
  output mvmp_pkg::red_t  dout
);
  import mvmp_pkg::*;
  red_t r_nxt;
  logic [VAL_W:0] t;
  always_comb begin
    r_nxt = din;
    t = '0;
    for (int i = 0; i < RED_BITS; i++) begin
      t = {r_nxt.r, r_nxt.acc[ACC_W-1]};
      r_nxt.acc = {r_nxt.acc[ACC_W-2:0], 1'b0};
      if (t >= {1'b0, r_nxt.p}) t = t - {1'b0, r_nxt.p};
      r_nxt.r = t[VAL_W-1:0];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) dout.vld <= 1'b0;
    else dout.vld <= din.vld;
    dout.idx <= r_nxt.idx;
    dout.last_col <= r_nxt.last_col;
    dout.zero_mod <= r_nxt.zero_mod;
    dout.p <= r_nxt.p;
    dout.r <= r_nxt.r;
    dout.acc <= r_nxt.acc;
  end
endmodule
`default_nettype wire

FILE: rtl/modular_vector_matrix_product.sv
// ----------------------------------------------------------------------------
// modular_vector_matrix_product: b = e^T * M mod p
// Column accumulators in RAM, reduction through a chain of cells.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_     | in  | coefficient, element, final_row
//  out_    | out | column_index, reduced_sum, final_column
//  cfg_    | in  | we, index, data (write only)
// One item at a time: accept (accumulator read), multiply, then add and write
// back. A final-row item then passes the RED_CELLS (24) cells of the reduction
// chain, and its result is then presented on out_.
// A clearing pass over all MAX_COLUMNS accumulators follows reset, with in_ready low.
// A pending result holds until out_ready; no new item is taken meanwhile.
`default_nettype none
module modular_vector_matrix_product #(
  parameter int MAX_COLUMNS = 1024
) (
  input  wire                        clk,
  input  wire                        rst_n,
  mvmp_in_if.sink                    in_ch,
  mvmp_out_if.source                 out_ch,
  input  wire                        cfg_we,
  input  wire                        cfg_index,
  input  wire [mvmp_pkg::VAL_W-1:0]  cfg_data
);
  import mvmp_pkg::*;
  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_MUL = 3'd2,
                         S_ADD = 3'd3, S_RED = 3'd4, S_OUT = 3'd5;

  logic [2:0] st_r, st_nxt;
  val_t mod_r;
  logic [CNT_W-1:0] cnt_r;
  logic [AW:0] clr_r;
  logic [AW-1:0] pos_r, cur_r;
  val_t a_r, b_r;
  logic fin_r, lastc_r;
  logic [PROD_W-1:0] prod_r;
  acc_t sum_r;
  red_t chain [RED_CELLS+1];
  logic [IDX_W-1:0] oidx_r;
  val_t osum_r;
  logic ofc_r, ovld_r;

  logic ram_we;
  logic [AW-1:0] ram_wa;
  acc_t ram_wd, ram_rd;
  acc_t sum_add;
  logic [CNT_W-1:0] eff_cnt;
  logic lc;

  mvmp_ram #(.WIDTH(ACC_W), .DEPTH(MAX_COLUMNS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
    .raddr(pos_r), .rdata(ram_rd));

  always_comb begin
    eff_cnt = cnt_r;
    if (cnt_r == '0) eff_cnt = CNT_W'(1);
    if ({21'd0, eff_cnt} > 32'(MAX_COLUMNS)) eff_cnt = CNT_W'(MAX_COLUMNS);
    lc = ({{(32-AW){1'b0}}, pos_r} + 32'd1) >= {21'd0, eff_cnt};
    sum_add = sum_r + ACC_W'(prod_r);
    ram_we = (st_r == S_CLR) || (st_r == S_ADD);
    ram_wa = (st_r == S_CLR) ? clr_r[AW-1:0] : cur_r;
    ram_wd = (st_r == S_CLR || fin_r) ? '0 : sum_add;
  end

  assign in_ch.ready = (st_r == S_IDLE);

  always_comb begin
    chain[0].vld = (st_r == S_ADD) && fin_r;
    chain[0].idx = IDX_W'(cur_r);
    chain[0].last_col = lastc_r;
    chain[0].zero_mod = (mod_r < VAL_W'(2));
    chain[0].p = mod_r;
    chain[0].r = '0;
    chain[0].acc = sum_add;
  end
  for (genvar g = 0; g < RED_CELLS; g++) begin : g_cell
    mvmp_red_cell u_cell (.clk(clk), .rst_n(rst_n), .din(chain[g]), .dout(chain[g+1]));
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_CLR:  if (clr_r == (AW+1)'(MAX_COLUMNS - 1)) st_nxt = S_IDLE;
      S_IDLE: if (in_ch.valid) st_nxt = S_MUL;
      S_MUL:  st_nxt = S_ADD;
      S_ADD:  st_nxt = fin_r ? S_RED : S_IDLE;
      S_RED:  if (chain[RED_CELLS].vld) st_nxt = S_OUT;
      S_OUT:  if (out_ch.ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; mod_r <= VAL_W'(2); cnt_r <= CNT_W'(1);
      clr_r <= '0; pos_r <= '0; ovld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we && cfg_index == CFG_MODULUS) mod_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_COLUMN_COUNT) cnt_r <= cfg_data[CNT_W-1:0];
      if (st_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (st_r == S_IDLE && in_ch.valid) begin
        pos_r <= lc ? '0 : pos_r + 1'b1;
      end
      if (st_r == S_RED && chain[RED_CELLS].vld) ovld_r <= 1'b1;
      else if (st_r == S_OUT && out_ch.ready) ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && in_ch.valid) begin
      a_r <= in_ch.coefficient; b_r <= in_ch.element; fin_r <= in_ch.final_row;
      cur_r <= pos_r; lastc_r <= lc;
    end
    if (st_r == S_MUL) prod_r <= PROD_W'(a_r) * PROD_W'(b_r);
    if (st_r == S_MUL) sum_r <= ram_rd;
    if (chain[RED_CELLS].vld) begin
      oidx_r <= chain[RED_CELLS].idx;
      osum_r <= chain[RED_CELLS].zero_mod ? '0 : chain[RED_CELLS].r;
      ofc_r  <= chain[RED_CELLS].last_col;
    end
  end

  assign out_ch.valid = ovld_r;
  assign out_ch.column_index = oidx_r;
  assign out_ch.reduced_sum = osum_r;
  assign out_ch.final_column = ofc_r;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid) else $error("ready while result pending");
  a_sum_lt_p: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.reduced_sum < mod_r || mod_r < VAL_W'(2)))
    else $error("reduced sum not below modulus");
`endif
endmodule
`default_nettype wire

FILE: tb/mvmp_tb_if.sv
// ----------------------------------------------------------------------------
// mvmp_tb_if: testbench notes for the channel interfaces
// The channel interfaces come with the RTL; this file holds shared tb types.
// ----------------------------------------------------------------------------
`default_nettype none
package mvmp_tb_pkg;
  typedef struct packed {
    logic [9:0]  column_index;
    logic [36:0] reduced_sum;
    logic        final_column;
  } column_result_t;
endpackage
`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for modular_vector_matrix_product
// Streams matrix elements through the input channel, predicts each column sum
// mod p in a behavioral accumulator model and compares every result item.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  import mvmp_pkg::*;
  import mvmp_tb_pkg::*;

  localparam int NCOL = 1024;
  localparam logic [36:0] PMAX = 37'h1F_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_MODULUS;
  logic [VAL_W-1:0] cfg_data = '0;

  mvmp_in_if  in_ch();
  mvmp_out_if out_ch();

  modular_vector_matrix_product i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [95:0] col_acc [NCOL];
  logic [9:0]  col_pos;
  logic [36:0] mod_reg;
  logic [10:0] count_reg;
  column_result_t pending_sums[$];
  int errors = 0;
  int n_results = 0;
  int n_items = 0;
  int src_idle = 0;
  int snk_idle = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.coefficient = '0;
    in_ch.element = '0;
    in_ch.final_row = 1'b0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [36:0] mod96(logic [95:0] v, logic [36:0] p);
    logic [37:0] r;
    r = '0;
    if (p < 2) return '0;
    for (int i = 95; i >= 0; i--) begin
      r = {r[36:0], v[i]};
      if (r >= {1'b0, p}) r = r - {1'b0, p};
    end
    return r[36:0];
  endfunction

  task automatic accumulate_element(logic [36:0] c, logic [36:0] e, logic fr);
    int cnt;
    logic [9:0] pos;
    logic last;
    column_result_t res;
    cnt = (count_reg == 0) ? 1 : (count_reg > NCOL ? NCOL : count_reg);
    pos = col_pos;
    last = (int'(pos) + 1 >= cnt);
    col_acc[pos] = col_acc[pos] + 96'(74'(c) * 74'(e));
    if (fr) begin
      res.column_index = pos;
      res.reduced_sum = mod96(col_acc[pos], mod_reg);
      res.final_column = last;
      pending_sums = {pending_sums, res};
      col_acc[pos] = '0;
    end
    col_pos = last ? '0 : pos + 1'b1;
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, n_results);
  endtask

  // result side: random stall, compare at the accepting edge
  always @(posedge clk) begin
    column_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_sums.size() == 0) begin
        report("unexpected result", out_ch.column_index, 0);
      end else begin
        exp_r = pending_sums.pop_front();
        if (out_ch.column_index !== exp_r.column_index)
          report("column_index", out_ch.column_index, exp_r.column_index);
        if (out_ch.reduced_sum !== exp_r.reduced_sum)
          report("reduced_sum", out_ch.reduced_sum, exp_r.reduced_sum);
        if (out_ch.final_column !== exp_r.final_column)
          report("final_column", out_ch.final_column, exp_r.final_column);
      end
      n_results++;
    end
    out_ch.ready <= ($urandom_range(99) >= snk_idle);
  end

  task automatic write_reg(logic idx, logic [36:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MODULUS) mod_reg = v;
    else count_reg = v[10:0];
    @(posedge clk);
  endtask

  // drive one item, waiting out idle cycles and the handshake; valid stays
  // high after the accept until the next item or a drain
  task automatic send_item(logic [36:0] c, logic [36:0] e, logic fr);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.coefficient <= c;
    in_ch.element <= e;
    in_ch.final_row <= fr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    accumulate_element(c, e, fr);
    n_items++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_matrix(int ncols, logic [36:0] p);
    int rows;
    logic [36:0] c;
    rows = $urandom_range(1, 4);
    for (int r = 0; r < rows; r++) begin
      c = (p > 1) ? 37'($urandom_range(0, 32'hFFFF_FFFF)) % p : '0;
      if ($urandom_range(9) == 0) c = p - 1;
      for (int k = 0; k < ncols; k++)
        send_item(c, (p > 1) ? 37'({$urandom, $urandom} % p) : '0, r == rows - 1);
    end
  endtask

  // directed table: coefficient, element, final_row, expected sum (when known)
  typedef struct {
    logic [36:0] c;
    logic [36:0] e;
    logic        fr;
    logic        known;
    logic [36:0] want;
  } dir_row_t;

  initial begin
    dir_row_t rows[$];
    logic [36:0] p;
    int ncols;
    int last_q;
    for (int i = 0; i < NCOL; i++) col_acc[i] = '0;
    col_pos = '0;
    mod_reg = 37'd2;
    count_reg = 11'd1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, then extremes with large p and 3 columns
    rows = '{'{37'd1, 37'd1, 1'b1, 1'b1, 37'd1}, '{37'd0, 37'd0, 1'b1, 1'b1, 37'd0},
             '{PMAX, PMAX, 1'b1, 1'b1, 37'd1}};
    foreach (rows[i]) begin
      send_item(rows[i].c, rows[i].e, rows[i].fr);
      last_q = pending_sums.size() - 1;
      if (rows[i].known) pending_sums[last_q].reduced_sum = rows[i].want;
    end
    drain();
    write_reg(CFG_MODULUS, 37'h1F_FFFF_FFE7);
    write_reg(CFG_COLUMN_COUNT, 37'd3);
    rows = '{'{PMAX, PMAX, 1'b0, 1'b0, 37'd0}, '{37'd0, PMAX, 1'b0, 1'b0, 37'd0},
             '{PMAX, 37'd0, 1'b0, 1'b0, 37'd0}, '{PMAX, PMAX, 1'b0, 1'b0, 37'd0},
             '{37'd1, 37'd5, 1'b0, 1'b0, 37'd0},
             '{37'h15_5555_5555, 37'h0A_AAAA_AAAA, 1'b0, 1'b0, 37'd0},
             '{PMAX, PMAX, 1'b1, 1'b0, 37'd0}, '{37'd7, 37'd9, 1'b1, 1'b0, 37'd0},
             '{37'd0, 37'd0, 1'b1, 1'b0, 37'd0}};
    foreach (rows[i]) begin
      send_item(rows[i].c, rows[i].e, rows[i].fr);
      last_q = pending_sums.size() - 1;
      if (rows[i].known) pending_sums[last_q].reduced_sum = rows[i].want;
    end
    drain();
    // lower the count mid-stream; zero count acts as one, oversize saturates
    send_item(37'd3, 37'd4, 1'b0);
    send_item(37'd3, 37'd4, 1'b0);
    drain();
    write_reg(CFG_COLUMN_COUNT, 37'd1);
    send_item(37'd2, 37'd2, 1'b1);
    drain();
    write_reg(CFG_COLUMN_COUNT, 37'd0);
    send_item(37'd5, 37'd6, 1'b1);
    send_item(37'd5, 37'd6, 1'b1);
    drain();
    write_reg(CFG_MODULUS, 37'd0);
    send_item(37'd9, 37'd9, 1'b1);
    drain();
    write_reg(CFG_MODULUS, 37'd1);
    send_item(37'd9, 37'd9, 1'b1);
    drain();
    write_reg(CFG_COLUMN_COUNT, 37'd2047);
    write_reg(CFG_MODULUS, 37'd3);
    send_item(37'd2, 37'd2, 1'b1);
    drain();

    // random phases: idle mix varies per phase; modulus and column count vary per round
    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 16 : (ph == 1) ? 54 : 0;
      snk_idle = (ph == 0) ? 54 : (ph == 1) ? 16 : 0;
      for (int m = 0; m < 6; m++) begin
        case ($urandom_range(3))
          0: p = 37'd2;
          1: p = 37'h1F_FFFF_FFE7;
          default: p = 37'($urandom_range(2, 32'hFFFF_FFFF)) |
                       {1'($urandom_range(1)), 36'd0};
        endcase
        ncols = (m == 5 && ph == 2) ? 1024 : $urandom_range(1, 12);
        drain();
        write_reg(CFG_MODULUS, p);
        write_reg(CFG_COLUMN_COUNT, 37'(ncols));
        // reset-column alignment: realign to column zero first
        while (col_pos != 0) send_item(37'd0, 37'd0, 1'b1);
        for (int k = 0; k < 3 && n_items < 720 * (ph + 1) / 3; k++)
          random_matrix(ncols == 1024 ? 1 : ncols, p);
        // hold the sender until everything has drained
        if (m == 2) drain();
      end
    end
    drain();
    $display("Covered %0d items and %0d column results over several moduli and widths.",
             n_items, n_results);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
